### rtl/sdq_pkg.sv
// shared constants, request and status codes, and cell control struct
package sdq_pkg;

	localparam int SDQ_CAPACITY = 16;
	localparam int SDQ_KEY_BITS = 32;
	localparam int SDQ_CNT_W    = $clog2(SDQ_CAPACITY + 1);

	localparam int REQ_W = 4;
	localparam int ST_W  = 2;

	localparam logic [REQ_W-1:0] REQ_INS_ORD   = 4'd0;
	localparam logic [REQ_W-1:0] REQ_INS_HEAD  = 4'd1;
	localparam logic [REQ_W-1:0] REQ_INS_FOOT  = 4'd2;
	localparam logic [REQ_W-1:0] REQ_POP_HEAD  = 4'd3;
	localparam logic [REQ_W-1:0] REQ_POP_FOOT  = 4'd4;
	localparam logic [REQ_W-1:0] REQ_REMOVE    = 4'd5;
	localparam logic [REQ_W-1:0] REQ_PEEK_HEAD = 4'd6;
	localparam logic [REQ_W-1:0] REQ_PEEK_FOOT = 4'd7;
	localparam logic [REQ_W-1:0] REQ_FIND      = 4'd8;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	// broadcast from control to every cell
	typedef struct packed {
		logic capture;   // latch hit flags for the beat just taken
		logic use_ge;    // hit where entry >= key
		logic use_eq;    // hit where entry == key
		logic use_head;  // hit at position 0
		logic use_foot;  // hit at last occupied position
		logic ins;       // open a slot after the last hit and load the key
		logic rmv;       // close the slot of the last hit
	} sdq_ctl_t;

endpackage

### rtl/sdq_req_if.sv
// request channel: valid/ready with request kind and key
interface sdq_req_if import sdq_pkg::*; #(
	parameter int KEY_BITS = SDQ_KEY_BITS
);
	logic                       valid;
	logic                       ready;
	logic [REQ_W-1:0]           req_type;
	logic signed [KEY_BITS-1:0] key;

	modport source(output valid, output req_type, output key, input ready);
	modport sink(input valid, input req_type, input key, output ready);
endinterface

### rtl/sdq_rsp_if.sv
// response channel: valid/ready with status, value and occupancy
interface sdq_rsp_if import sdq_pkg::*; #(
	parameter int KEY_BITS = SDQ_KEY_BITS,
	parameter int CNT_W    = SDQ_CNT_W
);
	logic                       valid;
	logic                       ready;
	logic [ST_W-1:0]            status;
	logic signed [KEY_BITS-1:0] value;
	logic [CNT_W-1:0]           occupancy;

	modport source(output valid, output status, output value, output occupancy, input ready);
	modport sink(input valid, input status, input value, input occupancy, output ready);
endinterface

### rtl/sdq_cell.sv
// one storage cell of the chain: holds an entry, its hit flag and shift logic
module sdq_cell import sdq_pkg::*; #(
	parameter int KEY_BITS = SDQ_KEY_BITS,
	parameter int CNT_W    = SDQ_CNT_W,
	parameter int IDX      = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sdq_ctl_t            ctl,
	input  logic [KEY_BITS-1:0] key_cmp,
	input  logic [KEY_BITS-1:0] key_ld,
	input  logic [CNT_W-1:0]    count,
	input  logic [KEY_BITS-1:0] prev_entry,
	input  logic [KEY_BITS-1:0] next_entry,
	input  logic                prev_any,
	input  logic                any_in,
	input  logic [KEY_BITS-1:0] val_in,
	output logic [KEY_BITS-1:0] entry,
	output logic                any_out,
	output logic [KEY_BITS-1:0] val_out
);

	localparam logic [CNT_W-1:0] POS     = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] POS_P1  = CNT_W'(IDX + 1);
	localparam bit               IS_HEAD = (IDX == 0);

	logic [KEY_BITS-1:0] entry_q;
	logic                hit_q;
	logic                hit_d;
	logic                occupied;
	logic                sel;

	assign occupied = (POS < count);

	always_comb begin
		hit_d = (ctl.use_foot && (POS_P1 == count))
			|| (occupied && ((ctl.use_ge && ($signed(entry_q) >= $signed(key_cmp)))
				|| (ctl.use_eq && (entry_q == key_cmp))
				|| (ctl.use_head && IS_HEAD)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.capture) begin
			hit_q <= hit_d;
		end
	end

	// any hit at this cell or above it
	assign any_out = hit_q | any_in;
	assign sel     = hit_q & ~any_in;
	assign val_out = val_in | (sel ? entry_q : '0);
	assign entry   = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			// key lands just after the last hit, cells above it move toward the foot
			if (prev_any && !any_out) begin
				entry_q <= key_ld;
			end else if (!prev_any && (POS <= count)) begin
				entry_q <= prev_entry;
			end
		end else if (ctl.rmv && !any_in) begin
			entry_q <= next_entry;
		end
	end

endmodule

### rtl/sdq_ctrl.sv
// request decode, occupancy count, hand-off to the chain and output register
module sdq_ctrl import sdq_pkg::*; #(
	parameter int CAPACITY = SDQ_CAPACITY,
	parameter int KEY_BITS = SDQ_KEY_BITS,
	parameter int CNT_W    = SDQ_CNT_W
) (
	input  logic                clk,
	input  logic                arst_n,
	sdq_req_if.sink             req,
	sdq_rsp_if.source           rsp,
	input  logic                found,
	input  logic [KEY_BITS-1:0] chain_val,
	output sdq_ctl_t            ctl,
	output logic [KEY_BITS-1:0] key_ld,
	output logic [CNT_W-1:0]    count
);

	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

	logic                busy_q;
	logic                out_v_q;
	logic [REQ_W-1:0]    type_s1;
	logic [KEY_BITS-1:0] key_s1;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic [ST_W-1:0]     status_q;
	logic [ST_W-1:0]     status_d;
	logic [KEY_BITS-1:0] value_q;
	logic [KEY_BITS-1:0] value_d;
	logic [CNT_W-1:0]    occ_q;
	logic                accept;
	logic                apply;
	logic                full;
	logic                is_ins;
	logic                is_rmv;
	logic                is_val;

	assign req.ready = ~busy_q;
	assign accept    = req.valid & ~busy_q;
	assign apply     = busy_q & (~out_v_q | rsp.ready);
	assign full      = (count_q == CAP);

	// hit selection for the beat being taken
	always_comb begin
		ctl.capture  = accept;
		ctl.use_ge   = 1'b0;
		ctl.use_eq   = 1'b0;
		ctl.use_head = 1'b0;
		ctl.use_foot = 1'b0;
		unique case (req.req_type)
			REQ_INS_ORD:   ctl.use_ge = 1'b1;
			REQ_INS_FOOT,
			REQ_POP_FOOT,
			REQ_PEEK_FOOT: ctl.use_foot = 1'b1;
			REQ_POP_HEAD,
			REQ_PEEK_HEAD: ctl.use_head = 1'b1;
			REQ_REMOVE,
			REQ_FIND:      ctl.use_eq = 1'b1;
			default:       ctl.use_ge = 1'b0;
		endcase
		ctl.ins = apply & is_ins & ~full;
		ctl.rmv = apply & is_rmv & found;
	end

	always_comb begin
		is_ins = 1'b0;
		is_rmv = 1'b0;
		is_val = 1'b0;
		unique case (type_s1)
			REQ_INS_ORD,
			REQ_INS_HEAD,
			REQ_INS_FOOT: is_ins = 1'b1;
			REQ_POP_HEAD,
			REQ_POP_FOOT,
			REQ_REMOVE: begin
				is_rmv = 1'b1;
				is_val = 1'b1;
			end
			REQ_PEEK_HEAD,
			REQ_PEEK_FOOT,
			REQ_FIND:     is_val = 1'b1;
			default:      is_val = 1'b0;
		endcase
	end

	always_comb begin
		priority if (is_ins) begin
			status_d = full ? ST_FULL : ST_DONE;
		end else if (is_val && found) begin
			status_d = ST_DONE;
		end else begin
			status_d = ST_EMPTY;
		end
		value_d = (is_val && found) ? chain_val : '0;
		if (ctl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.rmv) begin
			count_d = count_q - CNT_W'(1);
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			out_v_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (apply) begin
				busy_q <= 1'b0;
			end
			if (apply) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (apply) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1 <= req.req_type;
			key_s1  <= req.key;
		end
		if (apply) begin
			status_q <= status_d;
			value_q  <= value_d;
			occ_q    <= count_d;
		end
	end

	assign key_ld        = key_s1;
	assign count         = count_q;
	assign rsp.valid     = out_v_q;
	assign rsp.status    = status_q;
	assign rsp.value     = value_q;
	assign rsp.occupancy = occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("occupancy above capacity");

	a_ins_rmv_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.ins && ctl.rmv))
		else $error("insert and remove in the same cycle");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

	a_rmv_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rmv |-> count_q != '0)
		else $error("remove from an empty store");

	a_apply_frees: assert property (@(posedge clk) disable iff (!arst_n)
		apply |=> !busy_q && out_v_q)
		else $error("applied request did not reach the output register");

endmodule

### rtl/sorted_deque_with_match_remove.sv
// top level: bounded ordered deque of signed keys built from a chain of cells
//
// Requests arrive on req (req_type, key) and each one gives exactly one
// beat on rsp (status, value, occupancy), in request order.
// Kinds: ordered insert, insert at head or foot, pop head or foot, remove
// or find the equal key nearest the foot, peek head or foot.
// Every cell compares its entry with the key in the cycle the request beat
// is taken and registers a hit flag. When the output register can take a
// new response, the hit flags ripple along the chain, each cell shifts
// toward its neighbor or loads the key, and the response lands in the
// output register. The chain serves one request at a time: the next
// request is taken only after the previous one has been applied.
// A new request is taken while the previous response still waits on rsp;
// if rsp stays stalled, the following request holds in the chain and req
// drops ready until the output register frees.
// Reset clears the count, so the store starts empty; entry contents are
// not cleared and are only read below the count.
module sorted_deque_with_match_remove import sdq_pkg::*; #(
	parameter int CAPACITY = SDQ_CAPACITY,
	parameter int KEY_BITS = SDQ_KEY_BITS,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	sdq_req_if.sink   req,
	sdq_rsp_if.source rsp
);

	sdq_ctl_t            ctl;
	logic [KEY_BITS-1:0] key_ld;
	logic [CNT_W-1:0]    count;
	logic                any_c [CAPACITY+1];
	logic [KEY_BITS-1:0] val_c [CAPACITY+1];
	logic [KEY_BITS-1:0] ent_c [CAPACITY];

	assign any_c[CAPACITY] = 1'b0;
	assign val_c[CAPACITY] = '0;

	sdq_ctrl #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.found     (any_c[0]),
		.chain_val (val_c[0]),
		.ctl       (ctl),
		.key_ld    (key_ld),
		.count     (count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0] prev_entry;
		logic [KEY_BITS-1:0] next_entry;
		logic                prev_any;

		if (i == 0) begin : g_head
			assign prev_entry = '0;
			assign prev_any   = 1'b1;
		end else begin : g_body
			assign prev_entry = ent_c[i-1];
			assign prev_any   = any_c[i-1];
		end

		if (i == CAPACITY - 1) begin : g_foot
			assign next_entry = '0;
		end else begin : g_inner
			assign next_entry = ent_c[i+1];
		end

		sdq_cell #(
			.KEY_BITS (KEY_BITS),
			.CNT_W    (CNT_W),
			.IDX      (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key_cmp    (req.key),
			.key_ld     (key_ld),
			.count      (count),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.prev_any   (prev_any),
			.any_in     (any_c[i+1]),
			.val_in     (val_c[i+1]),
			.entry      (ent_c[i]),
			.any_out    (any_c[i]),
			.val_out    (val_c[i])
		);
	end

endmodule
